>>> rtl/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared types and constants of the flood source detector.
// ----------------------------------------------------------------------------
package fsd_pkg;

    localparam int SOURCE_SLOTS = 64;
    localparam int DENY_SLOTS   = 32;
    localparam int SLOT_AW      = $clog2(SOURCE_SLOTS);
    localparam int DENY_AW      = $clog2(DENY_SLOTS);

    localparam logic [31:0] RATE_THRESHOLD_RST = 32'd10000000;
    localparam logic [6:0]  STREAK_NEEDED_RST  = 7'd5;
    localparam logic [15:0] DENY_PERIODS_RST   = 16'd600;

    // configuration register indexes
    localparam logic [1:0] CFG_RATE_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_STREAK_NEEDED  = 2'd1;
    localparam logic [1:0] CFG_DENY_PERIODS   = 2'd2;

    // item kinds
    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // source table entry
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] total;
        logic [31:0] base;
        logic [6:0]  streak;
    } t_slot;

    // deny list entry
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] stamp;
    } t_deny;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRD,
        S_PCHK,
        S_DRD,
        S_DCHK,
        S_TRD,
        S_TCHK,
        S_IRD,
        S_ICHK,
        S_ERD,
        S_ECHK,
        S_DONE
    } t_state;

endpackage

>>> rtl/flood_source_detector.sv
// ----------------------------------------------------------------------------
// flood_source_detector
// Per-source byte counting with streak-based deny list and expiry.
// ----------------------------------------------------------------------------
// One request at a time. A packet scans the source table slot by slot (RAM
// read, then compare) and then the deny list entry by entry. A tick walks
// every slot; each slot that gets denied adds a deny-list search, and a final
// expiry pass walks the deny list. The scan of the source and deny RAMs, one
// entry per read, sets the length of each request. A new request is taken
// while the previous result still waits on the output register.
// ----------------------------------------------------------------------------
module flood_source_detector
    import fsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // request side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] source_address, [47:32] packet_bytes
    input  logic        s_tuser,   // [0] kind
    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] blocked, [1] table_full,
                                   // [8:2] newly_blocked, [14:9] expired, [15] 0
);

    t_state r_state, n_state;

    logic [31:0] r_rate_threshold;
    logic [6:0]  r_streak_needed;
    logic [15:0] r_deny_periods;

    logic [SOURCE_SLOTS-1:0] r_slot_valid, n_slot_valid;
    logic [DENY_SLOTS-1:0]   r_deny_valid, n_deny_valid;
    logic [31:0]             r_tick, n_tick;
    logic [SLOT_AW-1:0]      r_idx, n_idx;
    logic [DENY_AW-1:0]      r_didx, n_didx;
    logic [31:0]             r_key, n_key;
    logic [15:0]             r_bytes, n_bytes;
    logic                    r_is_tick, n_is_tick;
    logic                    r_blocked, n_blocked;
    logic                    r_full, n_full;
    logic [6:0]              r_added, n_added;
    logic [5:0]              r_removed, n_removed;
    logic                    r_mvalid, n_mvalid;
    logic [15:0]             r_mdata, n_mdata;

    // RAM ports
    logic               slot_we, slot_re, deny_we, deny_re;
    logic [SLOT_AW-1:0] slot_waddr;
    logic [DENY_AW-1:0] deny_waddr;
    t_slot              slot_wdata, slot_rdata;
    t_deny              deny_wdata, deny_rdata;

    fsd_ram #(.WIDTH($bits(t_slot)), .DEPTH(SOURCE_SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (slot_re),
        .i_raddr (r_idx),
        .o_rdata (slot_rdata)
    );

    fsd_ram #(.WIDTH($bits(t_deny)), .DEPTH(DENY_SLOTS)) u_deny_ram (
        .i_clk   (i_clk),
        .i_we    (deny_we),
        .i_waddr (deny_waddr),
        .i_wdata (deny_wdata),
        .i_re    (deny_re),
        .i_raddr (r_didx),
        .o_rdata (deny_rdata)
    );

    // lowest free slot / deny entry
    logic               slot_free_any, deny_free_any;
    logic [SLOT_AW-1:0] slot_free_idx;
    logic [DENY_AW-1:0] deny_free_idx;

    always_comb begin
        slot_free_any = 1'b0;
        slot_free_idx = '0;
        for (int i = SOURCE_SLOTS - 1; i >= 0; i--) begin
            if (!r_slot_valid[i]) begin
                slot_free_any = 1'b1;
                slot_free_idx = SLOT_AW'(i);
            end
        end
    end

    always_comb begin
        deny_free_any = 1'b0;
        deny_free_idx = '0;
        for (int i = DENY_SLOTS - 1; i >= 0; i--) begin
            if (!r_deny_valid[i]) begin
                deny_free_any = 1'b1;
                deny_free_idx = DENY_AW'(i);
            end
        end
    end

    // per-entry decode
    logic        accept, slot_last, deny_last, out_free;
    logic        slot_hit, deny_hit, slot_v, deny_v;
    logic [6:0]  need;
    logic [31:0] delta, age;
    logic [7:0]  streak_inc;
    logic        go_deny;

    assign accept     = s_tvalid && s_tready;
    assign slot_last  = (r_idx == SLOT_AW'(SOURCE_SLOTS - 1));
    assign deny_last  = (r_didx == DENY_AW'(DENY_SLOTS - 1));
    assign out_free   = !r_mvalid || m_tready;
    assign slot_v     = r_slot_valid[r_idx];
    assign deny_v     = r_deny_valid[r_didx];
    assign slot_hit   = slot_v && (slot_rdata.addr == r_key);
    assign deny_hit   = deny_v && (deny_rdata.addr == r_key);
    assign need       = (r_streak_needed == '0) ? 7'd1 : r_streak_needed;
    assign delta      = slot_rdata.total - slot_rdata.base;
    assign age        = r_tick - deny_rdata.stamp;
    assign streak_inc = {1'b0, slot_rdata.streak} + 8'd1;
    assign go_deny    = slot_v && (slot_rdata.base != '0) && (delta != '0)
                        && (delta >= r_rate_threshold) && (streak_inc >= {1'b0, need});

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_mvalid;
    assign m_tdata  = r_mdata;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = (s_tuser == KIND_TICK) ? S_TRD : S_PRD;
            S_PRD:  n_state = S_PCHK;
            S_PCHK: n_state = (slot_hit || slot_last) ? S_DRD : S_PRD;
            S_DRD:  n_state = S_DCHK;
            S_DCHK: n_state = (deny_hit || deny_last) ? S_DONE : S_DRD;
            S_TRD:  n_state = S_TCHK;
            S_TCHK: begin
                if (go_deny)        n_state = S_IRD;
                else if (slot_last) n_state = S_ERD;
                else                n_state = S_TRD;
            end
            S_IRD:  n_state = S_ICHK;
            S_ICHK: begin
                if (deny_hit || deny_last) n_state = slot_last ? S_ERD : S_TRD;
                else                       n_state = S_IRD;
            end
            S_ERD:  n_state = S_ECHK;
            S_ECHK: n_state = deny_last ? S_DONE : S_ERD;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_slot_valid = r_slot_valid;
        n_deny_valid = r_deny_valid;
        n_tick       = r_tick;
        n_idx        = r_idx;
        n_didx       = r_didx;
        n_key        = r_key;
        n_bytes      = r_bytes;
        n_is_tick    = r_is_tick;
        n_blocked    = r_blocked;
        n_full       = r_full;
        n_added      = r_added;
        n_removed    = r_removed;
        n_mvalid     = r_mvalid && !m_tready;
        n_mdata      = r_mdata;
        slot_we      = 1'b0;
        slot_re      = 1'b0;
        slot_waddr   = r_idx;
        slot_wdata   = slot_rdata;
        deny_we      = 1'b0;
        deny_re      = 1'b0;
        deny_waddr   = r_didx;
        deny_wdata   = deny_rdata;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx     = '0;
                    n_didx    = '0;
                    n_key     = s_tdata[31:0];
                    n_bytes   = s_tdata[47:32];
                    n_is_tick = (s_tuser == KIND_TICK);
                    n_blocked = 1'b0;
                    n_full    = 1'b0;
                    n_added   = '0;
                    n_removed = '0;
                    if (s_tuser == KIND_TICK) n_tick = r_tick + 32'd1;
                end
            end
            S_PRD: slot_re = 1'b1;
            S_PCHK: begin
                if (slot_hit) begin
                    slot_we          = 1'b1;
                    slot_wdata.total = slot_rdata.total + {16'd0, r_bytes};
                end else if (slot_last) begin
                    if (slot_free_any) begin
                        slot_we                     = 1'b1;
                        slot_waddr                  = slot_free_idx;
                        slot_wdata                  = '{addr: r_key, total: {16'd0, r_bytes},
                                                        base: '0, streak: '0};
                        n_slot_valid[slot_free_idx] = 1'b1;
                    end else begin
                        n_full = 1'b1;
                    end
                end else begin
                    n_idx = r_idx + SLOT_AW'(1);
                end
            end
            S_DRD: deny_re = 1'b1;
            S_DCHK: begin
                if (deny_hit)        n_blocked = 1'b1;
                else if (!deny_last) n_didx    = r_didx + DENY_AW'(1);
            end
            S_TRD: slot_re = 1'b1;
            S_TCHK: begin
                if (slot_v) begin
                    slot_we         = 1'b1;
                    slot_wdata.base = slot_rdata.total;
                    if (slot_rdata.base != '0) begin
                        if (delta == '0) begin
                            n_slot_valid[r_idx] = 1'b0;
                        end else if (delta < r_rate_threshold) begin
                            slot_wdata.streak = '0;
                        end else if (go_deny) begin
                            slot_wdata.streak = need - 7'd1;
                        end else begin
                            slot_wdata.streak = streak_inc[6:0];
                        end
                    end
                end
                if (go_deny) begin
                    n_key  = slot_rdata.addr;
                    n_didx = '0;
                end else if (!slot_last) begin
                    n_idx = r_idx + SLOT_AW'(1);
                end else begin
                    n_didx = '0;
                end
            end
            S_IRD: deny_re = 1'b1;
            S_ICHK: begin
                if (deny_hit) begin
                    deny_we    = 1'b1;
                    deny_wdata = '{addr: r_key, stamp: r_tick};
                    n_added    = r_added + 7'd1;
                end else if (deny_last && deny_free_any) begin
                    deny_we                     = 1'b1;
                    deny_waddr                  = deny_free_idx;
                    deny_wdata                  = '{addr: r_key, stamp: r_tick};
                    n_deny_valid[deny_free_idx] = 1'b1;
                    n_added                     = r_added + 7'd1;
                end
                if (deny_hit || deny_last) begin
                    n_didx = '0;
                    if (!slot_last) n_idx = r_idx + SLOT_AW'(1);
                end else begin
                    n_didx = r_didx + DENY_AW'(1);
                end
            end
            S_ERD: deny_re = 1'b1;
            S_ECHK: begin
                if (deny_v && (age > {16'd0, r_deny_periods})) begin
                    n_deny_valid[r_didx] = 1'b0;
                    n_removed            = r_removed + 6'd1;
                end
                if (!deny_last) n_didx = r_didx + DENY_AW'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    n_mvalid = 1'b1;
                    n_mdata  = {1'b0, r_removed, r_added, r_full, r_blocked};
                end
            end
            default: ;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_threshold <= RATE_THRESHOLD_RST;
            r_streak_needed  <= STREAK_NEEDED_RST;
            r_deny_periods   <= DENY_PERIODS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RATE_THRESHOLD: r_rate_threshold <= i_cfg_data;
                CFG_STREAK_NEEDED:  r_streak_needed  <= i_cfg_data[6:0];
                CFG_DENY_PERIODS:   r_deny_periods   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_valid <= '0;
            r_deny_valid <= '0;
            r_tick       <= '0;
            r_mvalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot_valid <= n_slot_valid;
            r_deny_valid <= n_deny_valid;
            r_tick       <= n_tick;
            r_mvalid     <= n_mvalid;
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_didx    <= n_didx;
        r_key     <= n_key;
        r_bytes   <= n_bytes;
        r_is_tick <= n_is_tick;
        r_blocked <= n_blocked;
        r_full    <= n_full;
        r_added   <= n_added;
        r_removed <= n_removed;
        r_mdata   <= n_mdata;
    end

    // checks
    a_rst_no_result: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    a_tick_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_is_tick) |-> (!r_blocked && !r_full))
        else $error("tick result carries packet flags");

    a_packet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_is_tick) |-> (r_added == '0 && r_removed == '0))
        else $error("packet result carries tick counts");

    a_one_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_deny_valid & ~n_deny_valid)
         + $countones(~r_deny_valid & n_deny_valid)) <= 1)
        else $error("more than one deny entry changed in a cycle");

endmodule

>>> rtl/fsd_ram.sv
// ----------------------------------------------------------------------------
// fsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
